// File: sv/msb_first_bit_packet_buffer_top_macros.svh
// Assertion macros shared by the packet buffer RTL.
`ifndef MSB_FIRST_BIT_PACKET_BUFFER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_PACKET_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFBP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mfbp_pkg.sv
`timescale 1ns / 1ps

package mfbp_pkg;

   localparam int FIELD_W          = 32;
   localparam int COUNT_W          = 6;
   localparam int POS_W            = 11;
   localparam int USED_W           = 12;
   localparam int CMD_W            = 2;
   localparam int BYTE_W           = 8;
   localparam int MAX_FIELD_BITS   = 32;
   localparam int BUFFER_BYTES_DEF = 256;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FIELD_W-1:0] field_value;
      logic [COUNT_W-1:0] bit_count;
      logic [POS_W-1:0]   read_position;
   } req_data_type;

   typedef struct packed {
      logic [FIELD_W-1:0] read_value;
      logic               error_flag;
      logic [USED_W-1:0]  used_bits;
   } rsp_data_type;

   // Command issue from the front end to the byte engine.
   typedef struct packed {
      logic               clear;
      logic               app_start;
      logic               rd_start;
      logic [FIELD_W-1:0] field_value;
      logic [COUNT_W-1:0] bit_count;
      logic [POS_W-1:0]   read_position;
   } core_ctl_type;

   // Completion report from the byte engine.
   typedef struct packed {
      logic               done;
      logic [FIELD_W-1:0] read_value;
   } core_sts_type;

endpackage

// File: sv/mfbp_req_if.sv
`timescale 1ns / 1ps

interface mfbp_req_if;
   logic                   valid;
   logic                   ready;
   mfbp_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mfbp_rsp_if.sv
`timescale 1ns / 1ps

interface mfbp_rsp_if;
   logic                   valid;
   logic                   ready;
   mfbp_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/msb_first_bit_packet_buffer_top.sv
`timescale 1ns / 1ps

// MSB-first bit packet buffer. Each request word carries a command: clear
// empties the buffer, append packs the low bit_count bits (0 to 32) of
// field_value right after the last written bit, first bit most significant,
// and read returns bit_count bits starting at read_position with the first
// bit read in the most significant place. Every freshly started byte begins
// as zero, so bits of the partial last byte past the written length read as
// zero. An append that would pass the capacity, a field wider than 32 bits,
// or a read that passes the last started byte is flagged in error_flag and
// changes nothing; read_value is zero for everything but a good read, and
// used_bits reports the length after the command. Exactly one response word
// follows each request word. The byte engine touches one byte of its memory
// per cycle, for each of the 1 to 5 bytes that an append or read field spans;
// clear, empty or rejected commands do no byte work. The response sits in an
// output register, so the next request word is taken while the previous
// response still waits for the sink. No clearing pass is needed after reset.
`include "msb_first_bit_packet_buffer_top_macros.svh"

module msb_first_bit_packet_buffer_top #(
   parameter int BUFFER_BYTES = mfbp_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mfbp_req_if.sink    req_if,
   mfbp_rsp_if.source  rsp_if
);

   localparam int CAP_BITS = BUFFER_BYTES * 8;
   localparam int LEN_W    = $clog2(CAP_BITS + 1);
   localparam int PW       = mfbp_pkg::POS_W;
   localparam int CW       = mfbp_pkg::COUNT_W;
   localparam int UW       = mfbp_pkg::USED_W;
   localparam int CMP_W    = ((LEN_W > PW) ? LEN_W : PW) + 2;
   localparam int BYTE_LSB_MASK = 7;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic wait_ff, wait_in;
   logic err_ff, err_in;
   logic rd_ok_ff, rd_ok_in;
   logic rsp_valid_ff, rsp_valid_in;
   mfbp_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   mfbp_pkg::core_ctl_type ctl;
   mfbp_pkg::core_sts_type sts;
   logic [LEN_W-1:0]       bit_length;

   logic             req_fire;
   logic             rsp_free;
   logic             finish;
   logic             count_ok;
   logic             append_ok;
   logic             read_ok;
   logic [CMP_W-1:0] app_end;
   logic [CMP_W-1:0] rd_end;
   logic [CMP_W-1:0] used_round;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign finish       = (state_ff == ST_BUSY) && !(wait_ff && !sts.done) && rsp_free;

   // Bounds: appends stop at capacity, reads stop at the last started byte.
   always_comb begin
      count_ok   = req_if.data.bit_count <= CW'(mfbp_pkg::MAX_FIELD_BITS);
      app_end    = CMP_W'(bit_length) + CMP_W'(req_if.data.bit_count);
      rd_end     = CMP_W'(req_if.data.read_position) + CMP_W'(req_if.data.bit_count);
      used_round = (CMP_W'(bit_length) + CMP_W'(BYTE_LSB_MASK)) & ~CMP_W'(BYTE_LSB_MASK);
      append_ok  = count_ok && (app_end <= CMP_W'(CAP_BITS));
      read_ok    = count_ok && (rd_end <= used_round);
   end

   // Decode the accepted word and hand any byte work to the engine.
   always_comb begin
      ctl               = '0;
      ctl.field_value   = req_if.data.field_value;
      ctl.bit_count     = req_if.data.bit_count;
      ctl.read_position = req_if.data.read_position;
      wait_in           = wait_ff && !sts.done;
      err_in            = err_ff;
      rd_ok_in          = rd_ok_ff;
      if (req_fire) begin
         err_in   = 1'b0;
         rd_ok_in = 1'b0;
         case (req_if.data.command)
            mfbp_pkg::CMD_CLEAR: begin
               ctl.clear = 1'b1;
            end
            mfbp_pkg::CMD_APPEND: begin
               if (!append_ok) begin
                  err_in = 1'b1;
               end else if (req_if.data.bit_count != '0) begin
                  ctl.app_start = 1'b1;
                  wait_in       = 1'b1;
               end
            end
            mfbp_pkg::CMD_READ: begin
               if (!read_ok) begin
                  err_in = 1'b1;
               end else if (req_if.data.bit_count != '0) begin
                  ctl.rd_start = 1'b1;
                  rd_ok_in     = 1'b1;
                  wait_in      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the response register once the engine is done and the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.read_value = rd_ok_ff ? sts.read_value : '0;
         rsp_data_in.error_flag = err_ff;
         rsp_data_in.used_bits  = UW'(bit_length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   mfbp_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .bit_length (bit_length)
   );

   `MFBP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_if.ready, "accepted while busy")
   `MFBP_ASSERT_IMPLY(a_done_expected, clock, reset, sts.done, wait_ff, "unexpected engine done")

endmodule

// File: sv/mfbp_core.sv
`timescale 1ns / 1ps

`include "msb_first_bit_packet_buffer_top_macros.svh"

module mfbp_core #(
   parameter int BUFFER_BYTES = mfbp_pkg::BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mfbp_pkg::core_ctl_type          ctl,
   output mfbp_pkg::core_sts_type          sts,
   output logic [$clog2(BUFFER_BYTES*8+1)-1:0] bit_length
);

   localparam int CAP_BITS = BUFFER_BYTES * 8;
   localparam int LEN_W    = $clog2(CAP_BITS + 1);
   localparam int IDX_W    = $clog2(BUFFER_BYTES);
   localparam int FW       = mfbp_pkg::FIELD_W;
   localparam int CW       = mfbp_pkg::COUNT_W;
   localparam int BW       = mfbp_pkg::BYTE_W;

   logic [BW-1:0] mem [BUFFER_BYTES];

   logic             app_busy_ff, app_busy_in;
   logic             rd_busy_ff, rd_busy_in;
   logic             done_ff, done_in;
   logic             rvld_ff, rvld_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [FW-1:0]    val_sr_ff, val_sr_in;
   logic [FW-1:0]    acc_ff, acc_in;
   logic [BW-1:0]    tail_ff, tail_in;
   logic [2:0]       off_ff, off_in;
   logic [IDX_W-1:0] raddr_ff, raddr_in;
   logic [BW-1:0]    rdata_ff;

   logic [2:0]       off;
   logic [3:0]       room;
   logic [3:0]       n;
   logic [BW-1:0]    chunk;
   logic [BW-1:0]    wbyte;
   logic [BW-1:0]    rbits;
   logic             wr_en;
   logic             last;

   always_comb begin
      // Bits that fit in the current byte, capped by what is left of the field.
      off  = app_busy_ff ? len_ff[2:0] : off_ff;
      room = 4'd8 - {1'b0, off};
      n    = (rem_ff < {2'b00, room}) ? rem_ff[3:0] : room;
      last = (rem_ff == {2'b00, n});

      chunk = val_sr_ff[FW-1 -: BW] & BW'(~(8'hFF >> n));
      wbyte = ((off == 3'd0) ? '0 : tail_ff) | (chunk >> off);
      rbits = BW'(rdata_ff << off) >> (4'd8 - n);

      app_busy_in = app_busy_ff;
      rd_busy_in  = rd_busy_ff;
      done_in     = 1'b0;
      len_in      = len_ff;
      rem_in      = rem_ff;
      val_sr_in   = val_sr_ff;
      acc_in      = acc_ff;
      tail_in     = tail_ff;
      off_in      = off_ff;
      raddr_in    = raddr_ff;
      rvld_in     = 1'b0;
      wr_en       = 1'b0;

      if (ctl.clear) begin
         len_in = '0;
      end else if (ctl.app_start) begin
         // Left-align the field so its first bit sits at the top.
         app_busy_in = 1'b1;
         rem_in      = ctl.bit_count;
         val_sr_in   = ctl.field_value << (CW'(FW) - ctl.bit_count);
      end else if (ctl.rd_start) begin
         rd_busy_in = 1'b1;
         rem_in     = ctl.bit_count;
         acc_in     = '0;
         off_in     = ctl.read_position[2:0];
         raddr_in   = IDX_W'(ctl.read_position >> 3);
      end else if (app_busy_ff) begin
         // One byte per cycle: merge into the tail byte and write it back.
         wr_en     = 1'b1;
         tail_in   = wbyte;
         len_in    = len_ff + LEN_W'(n);
         rem_in    = rem_ff - {2'b00, n};
         val_sr_in = val_sr_ff << n;
         if (last) begin
            app_busy_in = 1'b0;
            done_in     = 1'b1;
         end
      end else if (rd_busy_ff) begin
         // Issue the next byte address while consuming the previous byte.
         raddr_in = (raddr_ff == IDX_W'(BUFFER_BYTES - 1)) ? '0 : raddr_ff + 1'b1;
         rvld_in  = 1'b1;
         if (rvld_ff) begin
            acc_in = (acc_ff << n) | FW'(rbits);
            rem_in = rem_ff - {2'b00, n};
            off_in = 3'd0;
            if (last) begin
               rd_busy_in = 1'b0;
               rvld_in    = 1'b0;
               done_in    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         app_busy_ff <= 1'b0;
         rd_busy_ff  <= 1'b0;
         done_ff     <= 1'b0;
         rvld_ff     <= 1'b0;
         len_ff      <= '0;
      end else begin
         app_busy_ff <= app_busy_in;
         rd_busy_ff  <= rd_busy_in;
         done_ff     <= done_in;
         rvld_ff     <= rvld_in;
         len_ff      <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      val_sr_ff <= val_sr_in;
      acc_ff    <= acc_in;
      tail_ff   <= tail_in;
      off_ff    <= off_in;
      raddr_ff  <= raddr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[IDX_W'(len_ff >> 3)] <= wbyte;
      end
      rdata_ff <= mem[raddr_ff];
   end

   assign sts.done       = done_ff;
   assign sts.read_value = acc_ff;
   assign bit_length     = len_ff;

   `MFBP_ASSERT_IMPLY(a_len_in_cap, clock, reset, 1'b1, len_ff <= LEN_W'(CAP_BITS), "length past capacity")
   `MFBP_ASSERT_NEXT(a_app_progress, clock, reset, app_busy_ff, rem_ff < $past(rem_ff), "append stalled")
   `MFBP_ASSERT_IMPLY(a_done_from_work, clock, reset, done_ff, $past(app_busy_ff || rd_busy_ff), "stray done")

endmodule
